@@ rtl/mpls_pkg.sv @@
// shared types, constants and helpers of the motor power limit scaler
`default_nettype none
package mpls_pkg;

    localparam int MOTORS = 4;
    localparam int KBITS  = 16;
    localparam logic [16:0] K_ONE = 17'd65536;

    // configuration register indexes
    localparam logic [2:0] CFG_LOSS_K1      = 3'd0;
    localparam logic [2:0] CFG_LOSS_K2      = 3'd1;
    localparam logic [2:0] CFG_SPEED_TO_RAD = 3'd2;
    localparam logic [2:0] CFG_CUR_TO_TRQ   = 3'd3;
    localparam logic [2:0] CFG_CAP_THR      = 3'd4;
    localparam logic [2:0] CFG_FALLBACK     = 3'd5;

    // reset values
    localparam logic [15:0] RST_LOSS_K1      = 16'd11469;
    localparam logic [15:0] RST_LOSS_K2      = 16'd655;
    localparam logic [23:0] RST_SPEED_TO_RAD = 24'd91491;
    localparam logic [23:0] RST_CUR_TO_TRQ   = 24'd6144;
    localparam logic [15:0] RST_CAP_THR      = 16'd15;
    localparam logic [9:0]  RST_FALLBACK     = 10'd120;

    typedef struct packed {
        logic [15:0] loss_k1;
        logic [15:0] loss_k2;
        logic [23:0] speed_to_rad;
        logic [23:0] current_to_torque;
        logic [15:0] cap_thr;
        logic [9:0]  fallback;
    } t_cfg;

    // scale search state carried down the pipeline
    typedef struct packed {
        logic                    done;
        logic [16:0]             k;
        logic [53:0]             a;
        logic [49:0]             b;
        logic [57:0]             rhs;
        logic [57:0]             f;
        logic [MOTORS-1:0][15:0] cur;
    } t_srch;

    function automatic logic [15:0] mag16(input logic [15:0] v);
        mag16 = v[15] ? (16'd0 - v) : v;
    endfunction

    function automatic logic [4:0] offset_watts(input logic [9:0] p);
        if (p < 10'd80) begin
            offset_watts = 5'd10;
        end else if (p < 10'd100) begin
            offset_watts = 5'd13;
        end else if (p < 10'd120) begin
            offset_watts = 5'd15;
        end else begin
            offset_watts = 5'd20;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/motor_power_limit_scaler.sv @@
// top level of the motor power limit scaler
//
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_speed_a..d, i_current_a..d,
//                                                i_power_limit, i_cap_voltage
// output    out        o_out_valid / i_out_stall o_limited_a..d, o_scale_factor
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one transaction accepted per cycle unless o_in_stall is raised; 5 estimate stages,
// 32 search stages of two per scale bit and 1 output scaling stage
// the 16-bit scale search sets the depth: each bit costs a multiply stage
// and an add/compare stage
// synchronous active-low reset clears the valid bits and loads the
// register defaults
// the whole pipeline holds while a result waits under i_out_stall
`default_nettype none
module motor_power_limit_scaler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_speed_a,
    input  wire logic [15:0] i_speed_b,
    input  wire logic [15:0] i_speed_c,
    input  wire logic [15:0] i_speed_d,
    input  wire logic [15:0] i_current_a,
    input  wire logic [15:0] i_current_b,
    input  wire logic [15:0] i_current_c,
    input  wire logic [15:0] i_current_d,
    input  wire logic [9:0]  i_power_limit,
    input  wire logic [15:0] i_cap_voltage,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_limited_a,
    output logic [15:0]      o_limited_b,
    output logic [15:0]      o_limited_c,
    output logic [15:0]      o_limited_d,
    output logic [16:0]      o_scale_factor,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);

    // configuration registers
    mpls_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loss_k1           <= mpls_pkg::RST_LOSS_K1;
            r_cfg.loss_k2           <= mpls_pkg::RST_LOSS_K2;
            r_cfg.speed_to_rad      <= mpls_pkg::RST_SPEED_TO_RAD;
            r_cfg.current_to_torque <= mpls_pkg::RST_CUR_TO_TRQ;
            r_cfg.cap_thr           <= mpls_pkg::RST_CAP_THR;
            r_cfg.fallback          <= mpls_pkg::RST_FALLBACK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mpls_pkg::CFG_LOSS_K1:      r_cfg.loss_k1           <= i_cfg_data[15:0];
                mpls_pkg::CFG_LOSS_K2:      r_cfg.loss_k2           <= i_cfg_data[15:0];
                mpls_pkg::CFG_SPEED_TO_RAD: r_cfg.speed_to_rad      <= i_cfg_data;
                mpls_pkg::CFG_CUR_TO_TRQ:   r_cfg.current_to_torque <= i_cfg_data;
                mpls_pkg::CFG_CAP_THR:      r_cfg.cap_thr           <= i_cfg_data[15:0];
                mpls_pkg::CFG_FALLBACK:     r_cfg.fallback          <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // global advance: move whenever the output slot is free or being taken
    logic w_en;
    assign w_en       = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;

    logic [mpls_pkg::MOTORS-1:0][15:0] w_speed, w_cur;
    assign w_speed = {i_speed_d, i_speed_c, i_speed_b, i_speed_a};
    assign w_cur   = {i_current_d, i_current_c, i_current_b, i_current_a};

    logic            w_fr_valid, w_ks_valid;
    mpls_pkg::t_srch w_fr_srch, w_ks_srch;

    mpls_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_in_valid),
        .i_cfg         (r_cfg),
        .i_speed       (w_speed),
        .i_cur         (w_cur),
        .i_power_limit (i_power_limit),
        .i_cap_voltage (i_cap_voltage),
        .o_valid       (w_fr_valid),
        .o_srch        (w_fr_srch)
    );

    mpls_ksearch u_ksearch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_srch  (w_fr_srch),
        .o_valid (w_ks_valid),
        .o_srch  (w_ks_srch)
    );

    // output stage: scale each current, truncate toward zero
    logic [mpls_pkg::MOTORS-1:0][32:0] w_prod;
    logic [mpls_pkg::MOTORS-1:0][15:0] n_lim, r_lim;
    logic [16:0]                       r_k;
    logic                              r_out_valid;

    always_comb begin
        for (int m = 0; m < mpls_pkg::MOTORS; m++) begin
            w_prod[m] = 33'(mpls_pkg::mag16(w_ks_srch.cur[m])) * 33'(w_ks_srch.k);
            n_lim[m]  = w_ks_srch.cur[m][15] ? (16'd0 - w_prod[m][31:16]) : w_prod[m][31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_ks_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lim <= n_lim;
            r_k   <= w_ks_srch.k;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_limited_a    = r_lim[0];
    assign o_limited_b    = r_lim[1];
    assign o_limited_c    = r_lim[2];
    assign o_limited_d    = r_lim[3];
    assign o_scale_factor = r_k;

    // scale never exceeds one
    a_k_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_scale_factor <= mpls_pkg::K_ONE))
        else $error("scale factor above one");

    // zero scale gives zero currents
    a_k_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scale_factor == 17'd0) |->
        (o_limited_a == 16'd0 && o_limited_b == 16'd0 &&
         o_limited_c == 16'd0 && o_limited_d == 16'd0))
        else $error("nonzero current with zero scale");

    // input stalls only under output backpressure
    a_stall_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

endmodule
`default_nettype wire

@@ rtl/mpls_front.sv @@
// power estimate pipeline: speed and torque, power terms, limit decision
`default_nettype none
module mpls_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire mpls_pkg::t_cfg                        i_cfg,
    input  wire logic [mpls_pkg::MOTORS-1:0][15:0]     i_speed,
    input  wire logic [mpls_pkg::MOTORS-1:0][15:0]     i_cur,
    input  wire logic [9:0]                            i_power_limit,
    input  wire logic [15:0]                           i_cap_voltage,
    output logic                                       o_valid,
    output mpls_pkg::t_srch                            o_srch
);

    // stage 1: shaft speed and torque magnitudes
    logic [mpls_pkg::MOTORS-1:0][39:0] n1_wp, n1_tp;
    logic [9:0]                        n1_p;
    logic                              r1_valid, r1_lim;
    logic [mpls_pkg::MOTORS-1:0][23:0] r1_w, r1_t;
    logic [mpls_pkg::MOTORS-1:0][15:0] r1_cur;
    logic [9:0]                        r1_p;
    logic signed [10:0]                r1_poff;

    always_comb begin
        for (int m = 0; m < mpls_pkg::MOTORS; m++) begin
            n1_wp[m] = 40'(mpls_pkg::mag16(i_speed[m])) * 40'(i_cfg.speed_to_rad);
            n1_tp[m] = 40'(mpls_pkg::mag16(i_cur[m])) * 40'(i_cfg.current_to_torque);
        end
        n1_p = (i_power_limit == 10'd0) ? i_cfg.fallback : i_power_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < mpls_pkg::MOTORS; m++) begin
                r1_w[m] <= n1_wp[m][39:16];
                r1_t[m] <= n1_tp[m][39:16];
            end
            r1_cur  <= i_cur;
            r1_p    <= n1_p;
            r1_poff <= $signed({1'b0, n1_p}) - $signed({6'd0, mpls_pkg::offset_watts(n1_p)});
            r1_lim  <= (i_cap_voltage <= i_cfg.cap_thr);
        end
    end

    // stage 2: per-motor products
    logic                              r2_valid, r2_lim;
    logic [mpls_pkg::MOTORS-1:0][47:0] r2_wt, r2_tt, r2_ww;
    logic [mpls_pkg::MOTORS-1:0][15:0] r2_cur;
    logic [9:0]                        r2_p;
    logic signed [10:0]                r2_poff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < mpls_pkg::MOTORS; m++) begin
                r2_wt[m] <= 48'(r1_w[m]) * 48'(r1_t[m]);
                r2_tt[m] <= 48'(r1_t[m]) * 48'(r1_t[m]);
                r2_ww[m] <= 48'(r1_w[m]) * 48'(r1_w[m]);
            end
            r2_cur  <= r1_cur;
            r2_p    <= r1_p;
            r2_poff <= r1_poff;
            r2_lim  <= r1_lim;
        end
    end

    // stage 3: sums over motors
    logic [49:0]                       n3_pm, n3_tsq, n3_wsq;
    logic                              r3_valid, r3_lim;
    logic [49:0]                       r3_pm, r3_tsq, r3_wsq;
    logic [mpls_pkg::MOTORS-1:0][15:0] r3_cur;
    logic [9:0]                        r3_p;
    logic signed [10:0]                r3_poff;

    always_comb begin
        n3_pm  = '0;
        n3_tsq = '0;
        n3_wsq = '0;
        for (int m = 0; m < mpls_pkg::MOTORS; m++) begin
            n3_pm  = n3_pm  + 50'(r2_wt[m]);
            n3_tsq = n3_tsq + 50'(r2_tt[m]);
            n3_wsq = n3_wsq + 50'(r2_ww[m]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pm   <= n3_pm;
            r3_tsq  <= n3_tsq;
            r3_wsq  <= n3_wsq;
            r3_cur  <= r2_cur;
            r3_p    <= r2_p;
            r3_poff <= r2_poff;
            r3_lim  <= r2_lim;
        end
    end

    // stage 4: copper and speed loss
    logic [65:0]                       n4_ap, n4_sp;
    logic                              r4_valid, r4_lim, r4_tnz;
    logic [53:0]                       r4_a;
    logic [49:0]                       r4_sl, r4_pm;
    logic [mpls_pkg::MOTORS-1:0][15:0] r4_cur;
    logic [9:0]                        r4_p;
    logic signed [10:0]                r4_poff;

    assign n4_ap = 66'(r3_tsq) * 66'(i_cfg.loss_k1);
    assign n4_sp = 66'(r3_wsq) * 66'(i_cfg.loss_k2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_a    <= n4_ap[65:12];
            r4_sl   <= n4_sp[65:16];
            r4_pm   <= r3_pm;
            r4_tnz  <= (r3_tsq != 50'd0);
            r4_cur  <= r3_cur;
            r4_p    <= r3_p;
            r4_poff <= r3_poff;
            r4_lim  <= r3_lim;
        end
    end

    // stage 5: limit decision and search setup
    logic [52:0]        n5_pin;
    logic signed [52:0] n5_negc;
    logic [54:0]        n5_ab;
    mpls_pkg::t_srch    n5_srch;
    logic               r5_valid;
    mpls_pkg::t_srch    r5_srch;

    always_comb begin
        n5_pin  = 53'(r4_pm) + 53'(r4_a) + 53'(r4_sl);
        n5_negc = {{26{r4_poff[10]}}, r4_poff, 16'd0} - {3'd0, r4_sl};
        n5_ab   = 55'(r4_a) + 55'(r4_pm);
        n5_srch.done = 1'b1;
        n5_srch.k    = mpls_pkg::K_ONE;
        n5_srch.a    = r4_a;
        n5_srch.b    = r4_pm;
        n5_srch.rhs  = {n5_negc[25:0], 32'd0};
        n5_srch.f    = '0;
        n5_srch.cur  = r4_cur;
        if (n5_pin > {27'd0, r4_p, 16'd0} && r4_lim && r4_tnz) begin
            if (!(n5_negc > 53'sd0)) begin
                // root below zero
                n5_srch.k = 17'd0;
            end else if (n5_ab <= 55'(n5_negc[25:0])) begin
                n5_srch.k = mpls_pkg::K_ONE;
            end else begin
                n5_srch.done = 1'b0;
                n5_srch.k    = 17'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_srch <= n5_srch;
        end
    end

    assign o_valid = r5_valid;
    assign o_srch  = r5_srch;

endmodule
`default_nettype wire

@@ rtl/mpls_ksearch.sv @@
// pipelined bit-by-bit search for the current scale factor
`default_nettype none
module mpls_ksearch (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire mpls_pkg::t_srch i_srch,
    output logic                 o_valid,
    output mpls_pkg::t_srch      o_srch
);

    mpls_pkg::t_srch w_s [mpls_pkg::KBITS+1];
    logic            w_v [mpls_pkg::KBITS+1];

    assign w_s[0] = i_srch;
    assign w_v[0] = i_valid;

    // two stages per bit: multiply, then add and compare
    for (genvar j = 0; j < mpls_pkg::KBITS; j++) begin : g_bit
        localparam int B = mpls_pkg::KBITS - 1 - j;

        logic [16:0]     w_mult;
        logic            r_mv, r_sv;
        mpls_pkg::t_srch r_m, r_s, n_s;
        logic [70:0]     r_mp;
        logic [89:0]     w_inc, w_fn;

        // f(k + d) - f(k) = a*(2k + d)*d + b*2^16*d
        assign w_mult = {w_s[j].k[15:0], 1'b0} + (17'd1 << B);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv <= 1'b0;
                r_sv <= 1'b0;
            end else if (i_en) begin
                r_mv <= w_v[j];
                r_sv <= r_mv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m  <= w_s[j];
                r_mp <= 71'(w_s[j].a) * 71'(w_mult);
                r_s  <= n_s;
            end
        end

        always_comb begin
            w_inc = (90'(r_mp) << B) + (90'(r_m.b) << (16 + B));
            w_fn  = 90'(r_m.f) + w_inc;
            n_s   = r_m;
            if (!r_m.done && w_fn <= 90'(r_m.rhs)) begin
                n_s.k = r_m.k | (17'd1 << B);
                n_s.f = w_fn[57:0];
            end
        end

        assign w_s[j+1] = r_s;
        assign w_v[j+1] = r_sv;
    end

    assign o_valid = w_v[mpls_pkg::KBITS];
    assign o_srch  = w_s[mpls_pkg::KBITS];

endmodule
`default_nettype wire

@@ tb/motor_power_limit_scaler_test.sv @@
// testbench for the motor power limit scaler with scoreboard and stimulus
`default_nettype none
module motor_power_limit_scaler_test;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [63:0] SAT_TOP = 64'd1 << 62;

    // one motor sample set
    typedef struct packed {
        logic [3:0][15:0] speed;
        logic [3:0][15:0] current;
        logic [9:0]       plimit;
        logic [15:0]      cap;
    } t_sample;

    // one limited command set
    typedef struct packed {
        logic [3:0][15:0] limited;
        logic [16:0]      scale;
    } t_limited;

    // keeps the register copy, predicts the limited currents and checks them
    class limit_scoreboard;
        mpls_pkg::t_cfg regs;
        t_limited       pending_q[$];
        int             errors;

        function new();
            regs = '{mpls_pkg::RST_LOSS_K1, mpls_pkg::RST_LOSS_K2,
                     mpls_pkg::RST_SPEED_TO_RAD, mpls_pkg::RST_CUR_TO_TRQ,
                     mpls_pkg::RST_CAP_THR, mpls_pkg::RST_FALLBACK};
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] val);
            case (idx)
                mpls_pkg::CFG_LOSS_K1:      regs.loss_k1 = val[15:0];
                mpls_pkg::CFG_LOSS_K2:      regs.loss_k2 = val[15:0];
                mpls_pkg::CFG_SPEED_TO_RAD: regs.speed_to_rad = val;
                mpls_pkg::CFG_CUR_TO_TRQ:   regs.current_to_torque = val;
                mpls_pkg::CFG_CAP_THR:      regs.cap_thr = val[15:0];
                mpls_pkg::CFG_FALLBACK:     regs.fallback = val[9:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] magnitude(logic [15:0] v);
            logic [15:0] m;
            m = v[15] ? 16'd0 - v : v;
            return {48'd0, m};
        endfunction

        function logic [63:0] sat_mul(logic [63:0] x, logic [63:0] y);
            logic [63:0] p;
            if (y != 0 && x > SAT_TOP / y) begin
                return SAT_TOP;
            end
            p = x * y;
            return p > SAT_TOP ? SAT_TOP : p;
        endfunction

        function logic [63:0] sat_add(logic [63:0] x, logic [63:0] y);
            logic [63:0] s;
            s = x + y;
            return s > SAT_TOP ? SAT_TOP : s;
        endfunction

        // current scale from the loss quadratic, plus the scaled currents
        function t_limited limit_currents(t_sample s);
            t_limited r;
            logic [63:0] pmech, tsq, wsq, w, t, p, k, a, sloss, pin, negc, cand, lhs, m;
            logic [63:0] offs;
            longint c;
            pmech = 0;
            tsq = 0;
            wsq = 0;
            k = 64'd65536;
            for (int i = 0; i < 4; i++) begin
                w = (magnitude(s.speed[i]) * regs.speed_to_rad) >> 16;
                t = (magnitude(s.current[i]) * regs.current_to_torque) >> 16;
                pmech += w * t;
                tsq += t * t;
                wsq += w * w;
            end
            p = {54'd0, s.plimit};
            if (p == 0) begin
                p = {54'd0, regs.fallback};
            end
            offs = p < 80 ? 10 : p < 100 ? 13 : p < 120 ? 15 : 20;
            a = (tsq * regs.loss_k1) >> 12;
            sloss = (wsq * regs.loss_k2) >> 16;
            pin = pmech + a + sloss;
            if (pin > (p << 16) && s.cap <= regs.cap_thr && tsq != 0) begin
                c = longint'(sloss) - (longint'(p) - longint'(offs)) * 65536;
                if (c >= 0) begin
                    k = 0;
                end else begin
                    negc = -c;
                    if (a + pmech <= negc) begin
                        k = 64'd65536;
                    end else begin
                        k = 0;
                        for (int b = 15; b >= 0; b--) begin
                            cand = k | (64'd1 << b);
                            lhs = sat_add(sat_mul(sat_mul(a, cand), cand),
                                          sat_mul(sat_mul(pmech, cand), 64'd65536));
                            if (lhs <= (negc << 32)) begin
                                k = cand;
                            end
                        end
                    end
                end
            end
            for (int i = 0; i < 4; i++) begin
                m = (magnitude(s.current[i]) * k) >> 16;
                if (s.current[i][15]) begin
                    m = (64'h10000 - m) & 64'hFFFF;
                end
                r.limited[i] = m[15:0];
            end
            r.scale = k[16:0];
            return r;
        endfunction

        function void note_sample(t_sample s);
            pending_q.push_back(limit_currents(s));
        endfunction

        task report(string what, logic [23:0] got, logic [23:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_limited(t_limited got);
            t_limited want;
            if (pending_q.size() == 0) begin
                report("unexpected transaction", got.scale, 0);
                return;
            end
            want = pending_q.pop_front();
            for (int i = 0; i < 4; i++) begin
                if (got.limited[i] !== want.limited[i]) begin
                    report($sformatf("limited current %0d", i), got.limited[i],
                           want.limited[i]);
                end
            end
            if (got.scale !== want.scale) begin
                report("scale factor", got.scale, want.scale);
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_speed_a = '0, i_speed_b = '0, i_speed_c = '0, i_speed_d = '0;
    logic [15:0] i_current_a = '0, i_current_b = '0, i_current_c = '0, i_current_d = '0;
    logic [9:0]  i_power_limit = '0;
    logic [15:0] i_cap_voltage = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_limited_a, o_limited_b, o_limited_c, o_limited_d;
    logic [16:0] o_scale_factor;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = mpls_pkg::CFG_LOSS_K1;
    logic [23:0] i_cfg_data = '0;

    limit_scoreboard scoreboard = new();
    int  cycle_count = 0;
    int  accepted_count = 0;
    bit  no_idle = 1'b0;     // phase with both sides running flat out

    motor_power_limit_scaler DUT (.*);

    always #4 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function int pick_gap();
        if (no_idle || $urandom_range(0, 9) < 6) begin
            return 0;
        end
        return $urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // receiver: random stall, one long hold-off so the pipeline fills and backs up
    initial begin
        int run;
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!held && accepted_count > 300) begin
                hold_left = 400;
                held = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                run = pick_gap();
                i_out_stall <= run > 0;
                if (run > 1) begin
                    repeat (run - 1) @(posedge i_clk);
                end
            end
        end
    end

    // output monitor: inputs only move at the rising edge, so the falling edge
    // sees the values that the next rising edge accepts
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            scoreboard.check_limited('{'{o_limited_d, o_limited_c, o_limited_b, o_limited_a},
                                       o_scale_factor});
        end
    end

    // offers one transaction and holds it until it is taken
    task send_sample(t_sample s);
        bit taken;
        int gap;
        i_in_valid    <= 1'b1;
        i_speed_a     <= s.speed[0];
        i_speed_b     <= s.speed[1];
        i_speed_c     <= s.speed[2];
        i_speed_d     <= s.speed[3];
        i_current_a   <= s.current[0];
        i_current_b   <= s.current[1];
        i_current_c   <= s.current[2];
        i_current_d   <= s.current[3];
        i_power_limit <= s.plimit;
        i_cap_voltage <= s.cap;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
        scoreboard.note_sample(s);
        accepted_count++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // register write, only issued with the pipeline empty; the caller drops the enable
    task write_reg(logic [2:0] idx, logic [23:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        scoreboard.set_reg(idx, val);
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        while (scoreboard.pending_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task load_regs(logic [15:0] k1, logic [15:0] k2, logic [23:0] w2r, logic [23:0] c2t,
                   logic [15:0] thr, logic [9:0] fb);
        wait_drained();
        write_reg(mpls_pkg::CFG_LOSS_K1, k1);
        write_reg(mpls_pkg::CFG_LOSS_K2, k2);
        write_reg(mpls_pkg::CFG_SPEED_TO_RAD, w2r);
        write_reg(mpls_pkg::CFG_CUR_TO_TRQ, c2t);
        write_reg(mpls_pkg::CFG_CAP_THR, thr);
        write_reg(mpls_pkg::CFG_FALLBACK, fb);
        i_cfg_we <= 1'b0;
    endtask

    function t_sample make_sample(logic [15:0] spd, logic [15:0] cur, logic [9:0] pl,
                                  logic [15:0] cap);
        t_sample s;
        s.speed   = {spd, spd, spd, spd};
        s.current = {cur, 16'd0 - cur, cur, cur};
        s.plimit  = pl;
        s.cap     = cap;
        return s;
    endfunction

    // mostly heavy loads at low capacitor voltage so the scale search runs
    function t_sample random_sample();
        t_sample s;
        int sel;
        for (int i = 0; i < 4; i++) begin
            sel = $urandom_range(0, 9);
            s.speed[i] = sel < 2 ? 16'($urandom_range(0, 400) - 200) : 16'($urandom);
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                s.current[i] = 16'($urandom);
            end else if (sel < 4) begin
                s.current[i] = 16'($urandom_range(0, 600) - 300);
            end else begin
                s.current[i] = 16'($urandom_range(0, 32768) - 16384);
            end
        end
        s.plimit = $urandom_range(0, 9) == 0 ? 10'd0 : 10'($urandom);
        s.cap = $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom);
        return s;
    endfunction

    task random_run(int count);
        repeat (count) send_sample(random_sample());
    endtask

    initial begin
        logic [9:0] plims[8];
        plims = '{10'd0, 10'd79, 10'd80, 10'd99, 10'd100, 10'd119, 10'd120, 10'd1023};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every offset band, cap at and above threshold,
        // zero torque sum while limiting, most negative current passed through
        send_sample(make_sample(16'd0, 16'd0, 10'd0, 16'd0));
        send_sample(make_sample(16'h7FFF, 16'd16384, 10'd1023, 16'd0));
        send_sample(make_sample(16'h8000, 16'h8000, 10'd1, 16'd0));
        send_sample(make_sample(16'h8000, 16'h8000, 10'd500, 16'hFFFF));
        send_sample(make_sample(16'h7FFF, 16'h7FFF, 10'd1, 16'd15));
        send_sample(make_sample(16'h7FFF, 16'd12000, 10'd200, 16'd16));
        send_sample(make_sample(16'h7FFF, 16'd0, 10'd1, 16'd0));
        foreach (plims[i]) begin
            send_sample(make_sample(16'd6000, 16'd9000, plims[i], 16'd3));
            send_sample(make_sample(16'd2000, 16'd3000, plims[i], 16'd15));
        end
        send_sample(make_sample(16'd50, 16'd200, 10'd60, 16'd0));
        random_run(150);

        // all registers at their largest, no idling on either side
        load_regs(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 10'h3FF);
        no_idle = 1'b1;
        send_sample(make_sample(16'h8000, 16'h8000, 10'd0, 16'hFFFF));
        random_run(200);
        no_idle = 1'b0;

        // all registers zero: zero fallback limit and threshold
        load_regs(16'd0, 16'd0, 24'd0, 24'd0, 16'd0, 10'd0);
        send_sample(make_sample(16'd1000, 16'd1000, 10'd0, 16'd0));
        random_run(150);

        load_regs(16'd11469, 16'd655, 24'd91491, 24'd6144, 16'd0, 10'd0);
        random_run(200);

        repeat (4) begin
            load_regs(16'($urandom), 16'($urandom), 24'($urandom_range(0, 400000)),
                      24'($urandom_range(0, 60000)), 16'($urandom_range(0, 40)),
                      10'($urandom));
            random_run(180);
        end

        wait_drained();
        if (scoreboard.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
